// ===== hdl/ncts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest color tile search package
// Shared sizes, command codes, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package ncts_pkg;

  // Table size and the widths that follow from it
  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths
  localparam int CMD_W   = 1;
  localparam int INDEX_W = 11;
  localparam int COLOR_W = 24;
  localparam int CFG_W   = 12;

  localparam logic [CFG_W-1:0] ENTRY_COUNT_RESET = CFG_W'(2048);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] color_code;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] best_index;
    logic [COLOR_W-1:0] best_distance;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/nearest_color_tile_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest color tile search
// Holds a table of reference color codes and returns, for each query, the
// index of the nearest entry and its absolute distance (lowest index on tie).
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  -----------------------------
//  item      in         item_valid/item_stall  cmd, entry_index, color_code
//  result    out        result_valid/stall     best_index, best_distance
//  cfg       in         cfg_valid/cfg_ready    entry_count (12 bits)
//
//  A load produces no result. A query holds item_stall high through the
//  scan of N entries, N being entry_count clamped to 1..depth (one table
//  read per cycle through the single memory read port, one subtract and
//  compare per entry in the shared distance unit), then a drain state and
//  a hand-off state. The result register holds a finished answer while
//  result_stall is high; loads still transfer meanwhile, and a second
//  query waits in the hand-off state until the register frees up.
//  Reset (rst, synchronous) sets entry_count to 2048; table contents are
//  undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_color_tile_search (
  input  logic                        clk,
  input  logic                        rst,
  // item channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  ncts_pkg::item_t             item,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output ncts_pkg::result_t           result,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ncts_pkg::CFG_W-1:0]  cfg_data
);
  import ncts_pkg::*;

  // Table memory: one write port (loads), one registered read port (scan)
  logic [COLOR_W-1:0] reference_table [TABLE_DEPTH];
  logic [COLOR_W-1:0] rd_data;

  // Control and datapath registers
  state_t             state, state_next;
  logic [CFG_W-1:0]   entry_count;
  logic [COLOR_W-1:0] query_color;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_valid;
  logic               rd_last;
  logic [ADDR_W-1:0]  rd_idx;
  logic               first;
  logic [ADDR_W-1:0]  best_idx;
  logic [COLOR_W-1:0] best_dist;

  // Combinational signals
  logic               item_xfer;
  logic               load_xfer;
  logic               query_xfer;
  logic               result_xfer;
  logic [CNT_W-1:0]   limit;
  logic [ADDR_W-1:0]  last_addr;
  logic [COLOR_W-1:0] diff;
  logic               take;
  logic               result_load;

  assign item_stall  = (state != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign item_xfer   = item_valid && !item_stall;
  assign load_xfer   = item_xfer && (item.cmd == CMD_LOAD);
  assign query_xfer  = item_xfer && (item.cmd == CMD_QUERY);
  assign result_xfer = result_valid && !result_stall;

  // Clamp the search count to 1..TABLE_DEPTH
  always_comb begin
    priority if (entry_count == '0) begin
      limit = CNT_W'(1);
    end else if (entry_count > TABLE_DEPTH) begin
      limit = CNT_W'(TABLE_DEPTH);
    end else begin
      limit = CNT_W'(entry_count);
    end
  end

  assign last_addr = ADDR_W'(limit - CNT_W'(1));

  // Shared distance unit: absolute difference and running-minimum compare
  assign diff = (query_color >= rd_data) ? (query_color - rd_data)
                                         : (rd_data - query_color);
  // Strict less-than keeps the lowest index on a tie
  assign take = rd_valid && (first || (diff < best_dist));

  // Sequencer: next state
  always_comb begin
    state_next  = state;
    result_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (query_xfer) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_addr == last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Hold the answer until the result register is free
        if (!result_valid || !result_stall) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // Table write: drop loads that fall outside the table
  always_ff @(posedge clk) begin
    if (load_xfer && (item.entry_index < TABLE_DEPTH)) begin
      reference_table[ADDR_W'(item.entry_index)] <= item.color_code;
    end
  end

  // Table read
  always_ff @(posedge clk) begin
    rd_data <= reference_table[rd_addr];
  end

  // Scan address and read tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr  <= '0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
      rd_last  <= (state == ST_SCAN) && (rd_addr == last_addr);
      if (query_xfer) begin
        rd_addr <= '0;
      end else if (state == ST_SCAN) begin
        rd_addr <= rd_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    if (query_xfer) begin
      query_color <= item.color_code;
    end
  end

  // Running minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (query_xfer) begin
      first <= 1'b1;
    end else if (rd_valid) begin
      first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx  <= rd_idx;
      best_dist <= diff;
    end
  end

  // Result register: parts the scan from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_xfer) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.best_index    <= INDEX_W'(best_idx);
      result.best_distance <= best_dist;
    end
  end

  // Checks on the sequencer and scan pipeline
  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_addr <= last_addr))
    else $error("scan address passed the last entry");

  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && rd_last) |-> (state == ST_DRAIN))
    else $error("last compare outside the drain cycle");

  a_done_has_min: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !first)
    else $error("hand-off with no entry compared");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    query_xfer |=> (state == ST_SCAN) && (rd_addr == '0) && first)
    else $error("query did not start a fresh scan");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !result_load)
    else $error("pending result overwritten");

endmodule
